// ===== rtl/ptdh_pkg.sv =====
// Shared types and constants for the point/triangle depth hit block.
// Used by point_triangle_depth_hit and its port checker; no dependencies.
package ptdh_pkg;

    localparam int unsigned CfgIndexW = 3;
    localparam int unsigned CfgDataW  = 64;
    localparam int unsigned InDataW   = 96;
    localparam int unsigned OutDataW  = 40;
    localparam int unsigned OutPadW   = 7;

    // One in Q16.16; barycentric weights live in [0, OneQ16].
    localparam logic [16:0] OneQ16 = 17'h10000;

    localparam logic signed [35:0] DepthMax = 36'sh0_7FFF_FFFF;
    localparam logic signed [35:0] DepthMin = -36'sh0_8000_0000;
    localparam logic signed [31:0] DepthSatHi = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] DepthSatLo = 32'sh8000_0000;

    typedef enum logic [CfgIndexW-1:0] {
        REG_VERTEX0  = 3'd0,
        REG_VERTEX1  = 3'd1,
        REG_VERTEX2  = 3'd2,
        REG_DEPTHS01 = 3'd3,
        REG_DEPTH2   = 3'd4,
        REG_INV_ROW0 = 3'd5,
        REG_INV_ROW1 = 3'd6
    } cfg_reg_t;

    // Per-item control carried down the pipe.
    typedef struct packed {
        logic               mode;
        logic               far;      // mode 0 and start beyond every vertex depth
        logic               near;     // mode 0 and start at or below every vertex depth
        logic               bbox_in;
        logic signed [31:0] start;
    } ctl_t;

    // One edge after ordering, ready for the crossing multiply.
    typedef struct packed {
        logic               straddle;
        logic               both_right;
        logic               one_right;
        logic signed [32:0] dx;
        logic signed [32:0] dyp;
        logic signed [32:0] dxp;
        logic signed [32:0] dy;
    } edge_setup_t;

    typedef struct packed {
        logic               straddle;
        logic               both_right;
        logic               one_right;
        logic signed [65:0] lhs;
        logic signed [65:0] rhs;
    } edge_prod_t;

    function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

endpackage

// ===== rtl/point_triangle_depth_hit.sv =====
// Top level of the point/triangle depth hit block: a five-stage pipeline.
// Depends on ptdh_pkg for types, register codes and constants.
//
//  channel  | direction | word layout (lowest bit first)
//  ---------+-----------+--------------------------------------------------
//  s_*      | in        | tdata: point_x[31:0], point_y[63:32],
//           |           |        start_depth[95:64]; tuser: mode
//  m_*      | out       | tdata: hit[0], hit_depth[32:1], zero pad [39:33]
//  cfg_*    | in        | write enable, register index, 64-bit data
//
// Each accepted input word yields one result word, and one word can enter
// every cycle unless a stalled output has filled every stage. The two
// multiplier stages (edge crossing products and barycentric products, then
// the depth scaling products) set the stage boundaries. Reset clears every
// valid bit and all configuration registers. Each stage holds its word only
// while the stage after it is full and held, so bubbles close up and a
// stalled output does not block input until all five stages are full.
module point_triangle_depth_hit
    import ptdh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [InDataW-1:0]   s_tdata,    // point_x, point_y, start_depth
    input  logic [0:0]           s_tuser,    // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OutDataW-1:0]  m_tdata,    // hit, hit_depth, zero pad
    input  logic                 cfg_wen,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_wdata
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [63:0] vertex0_reg, vertex1_reg, vertex2_reg;
    logic [63:0] depths01_reg;
    logic [31:0] depth2_reg;
    logic [63:0] inv_row0_reg, inv_row1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex0_reg  <= '0;
            vertex1_reg  <= '0;
            vertex2_reg  <= '0;
            depths01_reg <= '0;
            depth2_reg   <= '0;
            inv_row0_reg <= '0;
            inv_row1_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_VERTEX0:  vertex0_reg  <= cfg_wdata;
                REG_VERTEX1:  vertex1_reg  <= cfg_wdata;
                REG_VERTEX2:  vertex2_reg  <= cfg_wdata;
                REG_DEPTHS01: depths01_reg <= cfg_wdata;
                REG_DEPTH2:   depth2_reg   <= cfg_wdata[31:0];
                REG_INV_ROW0: inv_row0_reg <= cfg_wdata;
                REG_INV_ROW1: inv_row1_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Unpacked views of the triangle. The user must change configuration only
    // while the pipe is empty (unenforced), so every stage may read these directly.
    logic signed [31:0] vx0, vy0, vx1, vy1, vx2, vy2;
    logic signed [31:0] dep0, dep1, dep2;
    logic signed [31:0] m00, m01, m10, m11;

    assign vx0  = vertex0_reg[63:32];
    assign vy0  = vertex0_reg[31:0];
    assign vx1  = vertex1_reg[63:32];
    assign vy1  = vertex1_reg[31:0];
    assign vx2  = vertex2_reg[63:32];
    assign vy2  = vertex2_reg[31:0];
    assign dep0 = depths01_reg[63:32];
    assign dep1 = depths01_reg[31:0];
    assign dep2 = depth2_reg;
    assign m00  = inv_row0_reg[63:32];
    assign m01  = inv_row0_reg[31:0];
    assign m10  = inv_row1_reg[63:32];
    assign m11  = inv_row1_reg[31:0];

    // ---------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or when the
    // stage after it loads.
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic en1, en2, en3, en4, en5;

    assign en5      = !out_valid_reg || m_tready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg        <= s_tvalid;
            if (en2) v2_reg        <= v1_reg;
            if (en3) v3_reg        <= v2_reg;
            if (en4) v4_reg        <= v3_reg;
            if (en5) out_valid_reg <= v4_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: compares against the vertices and edge setup.
    // ---------------------------------------------------------------
    logic               in_mode;
    logic signed [31:0] px, py, pd;

    assign in_mode = s_tuser[0];
    assign px      = s_tdata[31:0];
    assign py      = s_tdata[63:32];
    assign pd      = s_tdata[95:64];

    // Orders an edge so that its first end has the smaller y (then smaller
    // x) and prepares the terms of the exact intersection compare.
    function automatic edge_setup_t setup_edge(
        input logic signed [31:0] ux, input logic signed [31:0] uy,
        input logic signed [31:0] wx, input logic signed [31:0] wy,
        input logic signed [31:0] qx, input logic signed [31:0] qy);
        edge_setup_t        r;
        logic               swap;
        logic signed [31:0] ax, ay, bx, by;
        logic               xa, xb;
        swap = (wy < uy) || ((wy == uy) && (wx < ux));
        ax = swap ? wx : ux;
        ay = swap ? wy : uy;
        bx = swap ? ux : wx;
        by = swap ? uy : wy;
        xa = ax > qx;
        xb = bx > qx;
        r.straddle   = (ay >= qy) != (by >= qy);
        r.both_right = xa && xb;
        r.one_right  = xa ^ xb;
        r.dx  = sx33(bx) - sx33(ax);
        r.dyp = sx33(qy) - sx33(ay);
        r.dxp = sx33(qx) - sx33(ax);
        r.dy  = sx33(by) - sx33(ay);
        return r;
    endfunction

    ctl_t               s1_ctl_next, s1_ctl_reg;
    edge_setup_t        s1_edge_next [3];
    edge_setup_t        s1_edge_reg  [3];
    logic signed [32:0] s1_sx_next, s1_sy_next, s1_sx_reg, s1_sy_reg;

    always_comb
    begin
        logic signed [31:0] min_x, max_x, min_y, max_y;
        min_x = vx0;
        max_x = vx0;
        min_y = vy0;
        max_y = vy0;
        if (vx1 < min_x) min_x = vx1;
        if (vx2 < min_x) min_x = vx2;
        if (vx1 > max_x) max_x = vx1;
        if (vx2 > max_x) max_x = vx2;
        if (vy1 < min_y) min_y = vy1;
        if (vy2 < min_y) min_y = vy2;
        if (vy1 > max_y) max_y = vy1;
        if (vy2 > max_y) max_y = vy2;

        s1_ctl_next.mode    = in_mode;
        s1_ctl_next.far     = !in_mode && (pd > dep0) && (pd > dep1) && (pd > dep2);
        s1_ctl_next.near    = !in_mode && (pd <= dep0) && (pd <= dep1) && (pd <= dep2);
        s1_ctl_next.bbox_in = (px >= min_x) && (px <= max_x)
                           && (py >= min_y) && (py <= max_y);
        s1_ctl_next.start   = pd;

        s1_edge_next[0] = setup_edge(vx0, vy0, vx1, vy1, px, py);
        s1_edge_next[1] = setup_edge(vx1, vy1, vx2, vy2, px, py);
        s1_edge_next[2] = setup_edge(vx2, vy2, vx0, vy0, px, py);

        s1_sx_next = sx33(px) - sx33(vx0);
        s1_sy_next = sx33(py) - sx33(vy0);
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_ctl_reg  <= s1_ctl_next;
            s1_edge_reg <= s1_edge_next;
            s1_sx_reg   <= s1_sx_next;
            s1_sy_reg   <= s1_sy_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: crossing products for each edge and the four products of
    // the inverse projection with the point offset.
    // ---------------------------------------------------------------
    edge_prod_t         s2_prod_next [3];
    edge_prod_t         s2_prod_reg  [3];
    logic signed [64:0] s2_p00_next, s2_p01_next, s2_p10_next, s2_p11_next;
    logic signed [64:0] s2_p00_reg, s2_p01_reg, s2_p10_reg, s2_p11_reg;
    ctl_t               s2_ctl_reg;

    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            s2_prod_next[e].straddle   = s1_edge_reg[e].straddle;
            s2_prod_next[e].both_right = s1_edge_reg[e].both_right;
            s2_prod_next[e].one_right  = s1_edge_reg[e].one_right;
            s2_prod_next[e].lhs        = s1_edge_reg[e].dx * s1_edge_reg[e].dyp;
            s2_prod_next[e].rhs        = s1_edge_reg[e].dxp * s1_edge_reg[e].dy;
        end
        s2_p00_next = m00 * s1_sx_reg;
        s2_p01_next = m01 * s1_sy_reg;
        s2_p10_next = m10 * s1_sx_reg;
        s2_p11_next = m11 * s1_sy_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_ctl_reg  <= s1_ctl_reg;
            s2_prod_reg <= s2_prod_next;
            s2_p00_reg  <= s2_p00_next;
            s2_p01_reg  <= s2_p01_next;
            s2_p10_reg  <= s2_p10_next;
            s2_p11_reg  <= s2_p11_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: crossing count and clamped barycentric weights.
    // ---------------------------------------------------------------
    // floor(r / 2^16) limited to [0, one]
    function automatic logic [16:0] clamp_q16(input logic signed [65:0] r);
        logic [49:0] v;
        v = r[65:16];
        if (r[65])
            return '0;
        else if (v > 50'(OneQ16))
            return OneQ16;
        else
            return v[16:0];
    endfunction

    logic [2:0]         s3_cross;
    logic signed [65:0] s3_s_sum, s3_t_sum;
    logic [16:0]        s3_s_next, s3_t_next, s3_t_full, s3_t_cap;
    logic               s3_inside_next;
    logic [16:0]        s3_s_reg, s3_t_reg;
    logic               s3_inside_reg;
    ctl_t               s3_ctl_reg;

    always_comb
    begin
        for (int e = 0; e < 3; e++)
        begin
            s3_cross[e] = s2_prod_reg[e].straddle
                       && (s2_prod_reg[e].both_right
                           || (s2_prod_reg[e].one_right
                               && (s2_prod_reg[e].lhs >= s2_prod_reg[e].rhs)));
        end
        // Inside means the point is in the bounding box and exactly one edge is crossed.
        s3_inside_next = s2_ctl_reg.bbox_in
                      && ((s3_cross == 3'b001) || (s3_cross == 3'b010)
                          || (s3_cross == 3'b100));

        s3_s_sum  = s2_p00_reg + s2_p01_reg;
        s3_t_sum  = s2_p10_reg + s2_p11_reg;
        s3_s_next = clamp_q16(s3_s_sum);
        s3_t_full = clamp_q16(s3_t_sum);
        s3_t_cap  = OneQ16 - s3_s_next;
        s3_t_next = (s3_t_full > s3_t_cap) ? s3_t_cap : s3_t_full;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_ctl_reg    <= s2_ctl_reg;
            s3_inside_reg <= s3_inside_next;
            s3_s_reg      <= s3_s_next;
            s3_t_reg      <= s3_t_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: scale the depth differences by the weights.
    // ---------------------------------------------------------------
    logic signed [32:0] dd1, dd2;
    logic signed [50:0] s4_ps_next, s4_pt_next, s4_ps_reg, s4_pt_reg;
    logic               s4_inside_reg;
    ctl_t               s4_ctl_reg;

    assign dd1 = sx33(dep1) - sx33(dep0);
    assign dd2 = sx33(dep2) - sx33(dep0);
    assign s4_ps_next = $signed({1'b0, s3_s_reg}) * dd1;
    assign s4_pt_next = $signed({1'b0, s3_t_reg}) * dd2;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_ctl_reg    <= s3_ctl_reg;
            s4_inside_reg <= s3_inside_reg;
            s4_ps_reg     <= s4_ps_next;
            s4_pt_reg     <= s4_pt_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: depth sum, saturation and the result word.
    // ---------------------------------------------------------------
    logic signed [35:0] ext_dep0, ext_ps, ext_pt, depth_full;
    logic signed [31:0] depth_sat;
    logic               hit_next, hit_reg;
    logic signed [31:0] hit_depth_next, hit_depth_reg;

    always_comb
    begin
        // Dropping the low 16 bits of a two's complement product is a floor.
        ext_dep0   = {{4{dep0[31]}}, dep0};
        ext_ps     = {s4_ps_reg[50], s4_ps_reg[50:16]};
        ext_pt     = {s4_pt_reg[50], s4_pt_reg[50:16]};
        depth_full = ext_dep0 + ext_ps + ext_pt;
        if (depth_full > DepthMax)
            depth_sat = DepthSatHi;
        else if (depth_full < DepthMin)
            depth_sat = DepthSatLo;
        else
            depth_sat = depth_full[31:0];

        // Early outs first: start beyond the whole triangle, point outside,
        // or start in front of every vertex (a hit with no depth reported).
        if (s4_ctl_reg.far || !s4_inside_reg)
        begin
            hit_next       = 1'b0;
            hit_depth_next = '0;
        end
        else if (s4_ctl_reg.near)
        begin
            hit_next       = 1'b1;
            hit_depth_next = '0;
        end
        else
        begin
            hit_next       = s4_ctl_reg.mode || (s4_ctl_reg.start <= depth_sat);
            hit_depth_next = depth_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            hit_reg       <= hit_next;
            hit_depth_reg <= hit_depth_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OutPadW{1'b0}}, hit_depth_reg, hit_reg};

endmodule

// ===== rtl/ptdh_checker.sv =====
// Port-level checker for point_triangle_depth_hit, bound to the top level.
// Depends on ptdh_pkg for the word widths.
module ptdh_checker
    import ptdh_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutDataW-1:0] m_tdata
);

    // A result word that is not taken stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // Input is only refused when the whole pipe backs up behind the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input refused without an output stall");

    // A result appearing on an empty output came from an accepted input word.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 5))
        else $error("result word without matching input word");

    // Pad bits above the depth are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OutDataW-1:33] == '0)
        else $error("nonzero pad bits in result word");

endmodule

bind point_triangle_depth_hit ptdh_checker u_ptdh_checker (.*);
